FILE: rtl/dtp_pkg.sv
// shared types and constants of the dhcp option parser
`default_nettype none
package dtp_pkg;

   typedef enum logic [2:0] {
      PH_MAGIC = 3'd0,
      PH_TAG   = 3'd1,
      PH_LEN   = 3'd2,
      PH_VALUE = 3'd3,
      PH_SKIP  = 3'd4
   } phase_type;

   localparam logic [1:0] ST_END       = 2'd0;
   localparam logic [1:0] ST_MISMATCH  = 2'd1;
   localparam logic [1:0] ST_TRUNCATED = 2'd2;

   localparam logic [1:0] LEASE_NONE  = 2'd0;
   localparam logic [1:0] LEASE_OFFER = 2'd1;
   localparam logic [1:0] LEASE_ACK   = 2'd2;
   localparam logic [1:0] LEASE_NAK   = 2'd3;

   localparam logic [7:0] TAG_PAD    = 8'd0;
   localparam logic [7:0] TAG_SUBNET = 8'd1;
   localparam logic [7:0] TAG_MSG    = 8'd53;
   localparam logic [7:0] TAG_SERVER = 8'd54;
   localparam logic [7:0] TAG_END    = 8'hFF;

   localparam logic [7:0] MSG_OFFER = 8'd2;
   localparam logic [7:0] MSG_ACK   = 8'd5;
   localparam logic [7:0] MSG_NAK   = 8'd6;

   localparam logic [7:0] ADDR_LEN = 8'd4;

   localparam logic [1:0] COOKIE_LAST = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  lease_state;
      logic [31:0] subnet_mask;
      logic [31:0] server_address;
      logic        server_seen;
      logic        subnet_seen;
   } rsp_type;

   // expected magic cookie byte at each position
   function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h63;
         2'd1:    b = 8'h82;
         2'd2:    b = 8'h53;
         default: b = 8'h63;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/dtp_req_if.sv
// byte channel into the dhcp option parser
`default_nettype none
interface dtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/dtp_rsp_if.sv
// result channel out of the dhcp option parser
`default_nettype none
interface dtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [1:0]  lease_state;
   logic [31:0] subnet_mask;
   logic [31:0] server_address;
   logic        server_seen;
   logic        subnet_seen;

   modport source (output valid, output status, output lease_state, output subnet_mask,
                   output server_address, output server_seen, output subnet_seen,
                   input ready);
   modport sink   (input valid, input status, input lease_state, input subnet_mask,
                   input server_address, input server_seen, input subnet_seen,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/dhcp_option_tlv_parser.sv
// dhcp options field parser: magic cookie check, tlv walk, lease and address capture
//
// usage:
//   req_bus carries the options field one byte per transaction, last_byte marks
//   the final byte of a packet. rsp_bus carries exactly one result transaction
//   per packet: at the end tag, at the first wrong magic cookie byte, or at the
//   last byte when the walk was cut short. bytes after a result are dropped up
//   to and including the last byte; the next byte opens a new packet.
//   a byte accepted into the input register is parsed from there, and its result
//   is loaded into the result register that drives rsp_bus.
//   throughput: one byte per cycle; the parser state registers are updated
//   by one short step per byte, so nothing limits the rate but the handshakes.
//   a stalled receiver holds the result register; one more byte waits in the
//   input register, then req_bus.ready drops until the result is taken.
//   reset (synchronous): empty pipeline, magic check at cookie byte zero, lease
//   state none, stored subnet mask and server address cleared.
//   lease state and stored addresses persist across packets.
`default_nettype none
module dhcp_option_tlv_parser (
   input  wire logic clock,
   input  wire logic reset,
   dtp_req_if.sink   req_bus,
   dtp_rsp_if.source rsp_bus
);
   import dtp_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [1:0]  cookie_idx_ff, cookie_idx_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  len_ff, len_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] subnet_ff, subnet_in;
   logic [31:0] server_ff, server_in;
   logic [1:0]  lease_ff, lease_in;
   logic        subnet_seen_ff, subnet_seen_in;
   logic        server_seen_ff, server_seen_in;

   // per-byte step
   logic       out_free;
   logic       advance;
   logic       emit;
   logic [1:0] emit_status;
   logic       subnet_seen_upd, server_seen_upd;
   logic [7:0] left_dec;
   logic [31:0] shift_next;
   rsp_type    result;

   // a byte moves on only when the result register can take whatever it yields
   assign advance     = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || advance;
   assign in_valid_in = (req_bus.valid && req_bus.ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   assign left_dec   = left_ff - 8'd1;
   assign shift_next = {shift_ff[23:0], in_byte_ff};

   always_comb begin
      phase_in        = phase_ff;
      cookie_idx_in   = cookie_idx_ff;
      left_in         = left_ff;
      tag_in          = tag_ff;
      len_in          = len_ff;
      shift_in        = shift_ff;
      subnet_in       = subnet_ff;
      server_in       = server_ff;
      lease_in        = lease_ff;
      subnet_seen_upd = subnet_seen_ff;
      server_seen_upd = server_seen_ff;
      emit            = 1'b0;
      emit_status     = ST_END;

      if (advance) begin
         unique case (phase_ff)
            PH_MAGIC: begin
               if (in_byte_ff != cookie_byte(cookie_idx_ff)) begin
                  emit        = 1'b1;
                  emit_status = ST_MISMATCH;
                  phase_in    = PH_SKIP;
               end else if (cookie_idx_ff == COOKIE_LAST) begin
                  cookie_idx_in = 2'd0;
                  phase_in      = PH_TAG;
               end else begin
                  cookie_idx_in = cookie_idx_ff + 2'd1;
               end
            end
            PH_TAG: begin
               if (in_byte_ff == TAG_END) begin
                  emit        = 1'b1;
                  emit_status = ST_END;
                  phase_in    = PH_SKIP;
               end else if (in_byte_ff != TAG_PAD) begin
                  tag_in   = in_byte_ff;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               len_in   = in_byte_ff;
               left_in  = in_byte_ff;
               shift_in = 32'd0;
               phase_in = (in_byte_ff == 8'd0) ? PH_TAG : PH_VALUE;
            end
            PH_VALUE: begin
               // message type acts on its first value byte only
               if (tag_ff == TAG_MSG && left_ff == len_ff) begin
                  case (in_byte_ff)
                     MSG_OFFER: lease_in = LEASE_OFFER;
                     MSG_ACK:   lease_in = LEASE_ACK;
                     MSG_NAK:   lease_in = LEASE_NAK;
                     default:   lease_in = lease_ff;
                  endcase
               end
               shift_in = shift_next;
               left_in  = left_dec;
               if (left_dec == 8'd0) begin
                  if (len_ff == ADDR_LEN && tag_ff == TAG_SUBNET) begin
                     subnet_in       = shift_next;
                     subnet_seen_upd = 1'b1;
                  end else if (len_ff == ADDR_LEN && tag_ff == TAG_SERVER) begin
                     server_in       = shift_next;
                     server_seen_upd = 1'b1;
                  end
                  phase_in = PH_TAG;
               end
            end
            PH_SKIP: begin
               phase_in = PH_SKIP;
            end
            default: begin
               phase_in = PH_SKIP;
            end
         endcase

         if (in_last_ff) begin
            // walk cut short without a decisive byte
            if (!emit && phase_in != PH_SKIP) begin
               emit        = 1'b1;
               emit_status = ST_TRUNCATED;
            end
            phase_in      = PH_MAGIC;
            cookie_idx_in = 2'd0;
            left_in       = 8'd0;
            tag_in        = 8'd0;
            len_in        = 8'd0;
            shift_in      = 32'd0;
         end
      end

      subnet_seen_in = (advance && in_last_ff) ? 1'b0 : subnet_seen_upd;
      server_seen_in = (advance && in_last_ff) ? 1'b0 : server_seen_upd;

      result.status         = emit_status;
      result.lease_state    = lease_in;
      result.subnet_mask    = subnet_in;
      result.server_address = server_in;
      result.server_seen    = server_seen_upd;
      result.subnet_seen    = subnet_seen_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAGIC;
         cookie_idx_ff  <= 2'd0;
         left_ff        <= 8'd0;
         tag_ff         <= 8'd0;
         len_ff         <= 8'd0;
         shift_ff       <= 32'd0;
         subnet_ff      <= 32'd0;
         server_ff      <= 32'd0;
         lease_ff       <= LEASE_NONE;
         subnet_seen_ff <= 1'b0;
         server_seen_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         cookie_idx_ff  <= cookie_idx_in;
         left_ff        <= left_in;
         tag_ff         <= tag_in;
         len_ff         <= len_in;
         shift_ff       <= shift_in;
         subnet_ff      <= subnet_in;
         server_ff      <= server_in;
         lease_ff       <= lease_in;
         subnet_seen_ff <= subnet_seen_in;
         server_seen_ff <= server_seen_in;
      end
   end

   // result register toward rsp_bus
   dtp_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (result),
      .free      (out_free),
      .rsp_bus   (rsp_bus)
   );
endmodule
`default_nettype wire

FILE: rtl/dtp_rsp_stage.sv
// output register of the result channel
`default_nettype none
module dtp_rsp_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire dtp_pkg::rsp_type load_data,
   output logic                  free,
   dtp_rsp_if.source             rsp_bus
);
   import dtp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || rsp_bus.ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.status         = data_ff.status;
   assign rsp_bus.lease_state    = data_ff.lease_state;
   assign rsp_bus.subnet_mask    = data_ff.subnet_mask;
   assign rsp_bus.server_address = data_ff.server_address;
   assign rsp_bus.server_seen    = data_ff.server_seen;
   assign rsp_bus.subnet_seen    = data_ff.subnet_seen;
endmodule
`default_nettype wire
